// File: rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional list with insert and delete.
// ----------------------------------------------------------------------------
package plid_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             ins;   // shift up above idx, load at idx
        logic             del;   // shift down from idx upward
        logic [POS_W-1:0] idx;   // 0-based list index
    } cell_cmd_t;

endpackage

// File: rtl/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell
// One list entry: holds, loads, or takes the word of a neighbor cell.
// ----------------------------------------------------------------------------
module plid_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  plid_pkg::cell_cmd_t   cmd,
    input  logic [DATA_WIDTH-1:0] load_word,
    input  logic [DATA_WIDTH-1:0] below_word,
    input  logic [DATA_WIDTH-1:0] above_word,
    output logic [DATA_WIDTH-1:0] word,
    output logic [DATA_WIDTH-1:0] rd_word
);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic                  at_idx;
    logic                  above_idx;

    assign at_idx    = (int'(cmd.idx) == INDEX);
    assign above_idx = (int'(cmd.idx) < INDEX);

    always_comb
    begin
        priority if (cmd.ins && at_idx)
        begin
            word_next = load_word;
        end
        else if (cmd.ins && above_idx)
        begin
            word_next = below_word;
        end
        else if (cmd.del && (at_idx || above_idx))
        begin
            word_next = above_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = at_idx ? word_reg : '0;

endmodule

// File: rtl/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed words with read, insert and delete by position.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_ready | func, position, value_in
//  out     | output    | out_valid/out_ready | ok, value_out, count_out
//
// one transaction per cycle: every cell shifts or holds in parallel in the
// cycle the request is accepted, and the result lands in the output register
// a new request is taken whenever the output register is empty or drained
// in the same cycle, so a stalled output holds the input off
// reset clears the count and the output valid; entry contents stay unknown
// until written, and only written entries are ever read
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
    parameter int DEPTH      = plid_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [plid_pkg::FUNC_W-1:0]   func,
    input  logic        [plid_pkg::POS_W-1:0]    position,
    input  logic signed [plid_pkg::VALUE_W-1:0]  value_in,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 ok,
    output logic signed [plid_pkg::VALUE_W-1:0]  value_out,
    output logic        [plid_pkg::COUNT_W-1:0]  count_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W) + 1;

    // list fill
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // output register
    logic                                out_valid_reg;
    logic                                ok_reg;
    logic [plid_pkg::VALUE_W-1:0]        value_reg;
    logic [plid_pkg::COUNT_W-1:0]        count_out_reg;

    logic                                accept;
    logic [CMP_W-1:0]                    pos_c;
    logic [CMP_W-1:0]                    cnt_c;
    logic                                pos_nz;
    logic                                in_range;
    logic                                rd_ok;
    logic                                ins_ok;
    logic                                del_ok;
    logic                                op_ok;
    logic signed [63:0]                  vin_ext;
    logic [DATA_WIDTH-1:0]               store_word;
    logic [63:0]                         rd_wide;
    logic [15:0]                         cnt_wide;
    plid_pkg::cell_cmd_t                 cmd;

    // row of cells
    logic [DATA_WIDTH-1:0] cell_word [DEPTH];
    logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
    logic [DATA_WIDTH-1:0] rd_word;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // range checks against the current fill
    assign pos_c    = CMP_W'(position);
    assign cnt_c    = CMP_W'(count_reg);
    assign pos_nz   = (position != '0);
    assign in_range = pos_nz && (pos_c <= cnt_c);

    assign rd_ok  = (func == plid_pkg::FUNC_READ) && in_range;
    assign del_ok = (func == plid_pkg::FUNC_DELETE) && in_range;
    assign ins_ok = (func == plid_pkg::FUNC_INSERT) && (count_reg != CNT_W'(DEPTH))
                    && pos_nz && (pos_c <= cnt_c + CMP_W'(1));
    assign op_ok  = rd_ok || ins_ok || del_ok;

    // incoming word sign extended, then cut to the stored width
    assign vin_ext    = 64'(value_in);
    assign store_word = vin_ext[DATA_WIDTH-1:0];

    assign cmd.ins = accept && ins_ok;
    assign cmd.del = accept && del_ok;
    assign cmd.idx = position - plid_pkg::POS_W'(1);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] below;
            logic [DATA_WIDTH-1:0] above;

            if (gi == 0)
            begin : g_first
                assign below = store_word;
            end
            else
            begin : g_mid_lo
                assign below = cell_word[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign above = cell_word[gi];
            end
            else
            begin : g_mid_hi
                assign above = cell_word[gi+1];
            end

            plid_cell #(
                .INDEX      (gi),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .load_word  (store_word),
                .below_word (below),
                .above_word (above),
                .word       (cell_word[gi]),
                .rd_word    (cell_rd[gi])
            );
        end
    endgenerate

    // only the addressed cell drives a nonzero read word
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign rd_wide  = 64'(rd_word);
    assign cnt_wide = 16'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= op_ok;
            value_reg     <= (rd_ok || del_ok) ? rd_wide[plid_pkg::VALUE_W-1:0] : '0;
            count_out_reg <= cnt_wide[plid_pkg::COUNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign value_out = value_reg;
    assign count_out = count_out_reg;

endmodule
